### rtl/bba_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bba_pkg
// Shared widths, codes and reset values for the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int DEF_NUM_BLOCKS = 1024;

  localparam int CNT_W     = 11;
  localparam int ADDR_W    = 64;
  localparam int SIZE_W    = 17;
  localparam int STAT_W    = 2;
  localparam int CFG_IDX_W = 2;

  // Map words hold 32 block bits each
  localparam int WORD_BITS  = 32;
  localparam int WORD_IDX_W = $clog2(WORD_BITS);

  // Address offsets that can match a block fit in this many bits
  localparam int DVD_W = 33;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_MARK  = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOFREE  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_BADADDR = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT_ADDRESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_PITCH  = 2'd2;

  localparam logic [CNT_W-1:0]  RST_BLOCK_COUNT  = 11'd1024;
  localparam logic [ADDR_W-1:0] RST_ROOT_ADDRESS = 64'd0;
  localparam logic [SIZE_W-1:0] RST_BLOCK_PITCH  = 17'd4096;

endpackage
`default_nettype wire

### rtl/bitmap_block_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// First-fit block allocator over a used/free bitmap held in a word-wide RAM.
// ----------------------------------------------------------------------------
// Allocate: map words are streamed one per cycle; once the word holding the
//   first free block is read, its index is multiplied by the pitch and added
//   to the root address. Cache full gives its result the cycle after start.
// Mark: a 33-step serial divider finds the block index, then one RAM
//   read/modify/write. Block size zero scans like allocate.
// One command at a time; done pulses for one cycle, the receiver cannot stall.
// Reset clears the map word by word with busy held high.
// ----------------------------------------------------------------------------
module bitmap_block_allocator #(
  parameter int NUM_BLOCKS = bba_pkg::DEF_NUM_BLOCKS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            command,
  input  logic [bba_pkg::ADDR_W-1:0]      target_address,
  input  logic [bba_pkg::CNT_W-1:0]       cache_occupancy,
  input  logic                            cfg_we,
  input  logic [bba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bba_pkg::ADDR_W-1:0]      cfg_data,
  output logic                            done,
  output logic [bba_pkg::STAT_W-1:0]      status,
  output logic [bba_pkg::ADDR_W-1:0]      block_address
);
  import bba_pkg::*;

  localparam int MEM_DEPTH = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int KW        = AW + WORD_IDX_W;
  localparam int NB_W      = $clog2(NUM_BLOCKS + 1);
  localparam int LW        = (NB_W > CNT_W) ? NB_W : CNT_W;
  localparam int CW        = LW + 1;
  localparam int PW        = KW + SIZE_W;

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_SCAN  = 8'b0000_0100,
    ST_DIV   = 8'b0000_1000,
    ST_MRD   = 8'b0001_0000,
    ST_MCHK  = 8'b0010_0000,
    ST_MUL   = 8'b0100_0000,
    ST_ADD   = 8'b1000_0000
  } state_t;

  state_t state;

  logic [CNT_W-1:0]  block_count;
  logic [ADDR_W-1:0] root_address;
  logic [SIZE_W-1:0] block_pitch;

  logic              op_mark;
  logic [AW-1:0]     clr_addr;
  logic [AW:0]       scan_cnt;
  logic              chk_valid;
  logic [AW-1:0]     chk_word;
  logic [KW-1:0]     k_sel;
  logic [PW-1:0]     prod;
  logic              div_start;
  logic [DVD_W-1:0]  mark_off;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;
  logic [WORD_BITS-1:0] rd_data;

  logic                 div_done;
  logic [DVD_W-1:0]     div_quo;
  logic [SIZE_W-1:0]    div_rem;

  logic [LW-1:0]         limit;
  logic [CW-1:0]         nwords;
  logic [ADDR_W-1:0]     diff;
  logic                  issue;
  logic                  last_chk;
  logic [WORD_BITS-1:0]  valid_mask;
  logic [WORD_BITS-1:0]  free_bits;
  logic                  found;
  logic [WORD_IDX_W-1:0] free_idx;
  logic                  mark_used;

  // Blocks past the map or past the programmed count are never scanned
  always_comb begin
    if (LW'(block_count) >= LW'(NUM_BLOCKS)) begin
      limit = LW'(NUM_BLOCKS);
    end else begin
      limit = LW'(block_count);
    end
    nwords = (CW'(limit) + CW'(WORD_BITS - 1)) >> WORD_IDX_W;
    diff   = target_address - root_address;
    issue  = CW'(scan_cnt) < nwords;
  end

  always_comb begin
    last_chk = (CW'(chk_word) + CW'(1)) == nwords;
    if (last_chk && (limit[WORD_IDX_W-1:0] != '0)) begin
      valid_mask = (WORD_BITS'(1) << limit[WORD_IDX_W-1:0]) - WORD_BITS'(1);
    end else begin
      valid_mask = '1;
    end
    free_bits = ~rd_data & valid_mask;
    found     = |free_bits;
    free_idx  = '0;
    // lowest free bit wins
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        free_idx = WORD_IDX_W'(i);
      end
    end
    mark_used = rd_data[k_sel[WORD_IDX_W-1:0]];
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = chk_word;
    mem_wdata = rd_data | (WORD_BITS'(1) << free_idx);
    mem_re    = 1'b0;
    mem_raddr = scan_cnt[AW-1:0];
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      ST_SCAN: begin
        mem_re = issue;
        mem_we = chk_valid && found;
      end
      ST_MRD: begin
        mem_re    = 1'b1;
        mem_raddr = k_sel[KW-1:WORD_IDX_W];
      end
      ST_MCHK: begin
        mem_we    = !mark_used;
        mem_waddr = k_sel[KW-1:WORD_IDX_W];
        mem_wdata = rd_data | (WORD_BITS'(1) << k_sel[WORD_IDX_W-1:0]);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  bba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MEM_DEPTH),
    .AW    (AW)
  ) u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  bba_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (mark_off),
    .divisor   (block_pitch),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      done         <= 1'b0;
      div_start    <= 1'b0;
      chk_valid    <= 1'b0;
      block_count  <= RST_BLOCK_COUNT;
      root_address <= RST_ROOT_ADDRESS;
      block_pitch  <= RST_BLOCK_PITCH;
    end else begin
      done      <= 1'b0;
      div_start <= 1'b0;

      if (cfg_we) begin
        case (cfg_index)
          CFG_BLOCK_COUNT:  block_count  <= cfg_data[CNT_W-1:0];
          CFG_ROOT_ADDRESS: root_address <= cfg_data;
          CFG_BLOCK_PITCH:  block_pitch  <= cfg_data[SIZE_W-1:0];
          default:          ;
        endcase
      end

      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(MEM_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (start) begin
            op_mark   <= command;
            scan_cnt  <= '0;
            chk_valid <= 1'b0;
            // hold the target offset, the address port may move after the beat
            mark_off  <= diff[DVD_W-1:0];
            if (command == CMD_ALLOC) begin
              if (cache_occupancy >= block_count) begin
                done          <= 1'b1;
                status        <= STAT_FULL;
                block_address <= '0;
              end else begin
                state <= ST_SCAN;
              end
            end else if (block_pitch == '0) begin
              // every block sits at the root: take the lowest free one
              if ((diff == '0) && (limit != '0)) begin
                state <= ST_SCAN;
              end else begin
                done          <= 1'b1;
                status        <= STAT_BADADDR;
                block_address <= '0;
              end
            end else if (diff[ADDR_W-1:DVD_W] != '0) begin
              done          <= 1'b1;
              status        <= STAT_BADADDR;
              block_address <= '0;
            end else begin
              div_start <= 1'b1;
              state     <= ST_DIV;
            end
          end
        end

        ST_SCAN: begin
          if (issue) begin
            scan_cnt <= scan_cnt + (AW + 1)'(1);
          end
          chk_valid <= issue;
          chk_word  <= scan_cnt[AW-1:0];
          if (chk_valid) begin
            if (found) begin
              k_sel <= {chk_word, free_idx};
              if (op_mark) begin
                done          <= 1'b1;
                status        <= STAT_OK;
                block_address <= '0;
                state         <= ST_IDLE;
              end else begin
                state <= ST_MUL;
              end
            end else if (last_chk) begin
              done          <= 1'b1;
              status        <= op_mark ? STAT_BADADDR : STAT_NOFREE;
              block_address <= '0;
              state         <= ST_IDLE;
            end
          end
        end

        ST_DIV: begin
          if (div_done) begin
            if ((div_rem == '0) && (div_quo < DVD_W'(limit))) begin
              k_sel <= div_quo[KW-1:0];
              state <= ST_MRD;
            end else begin
              done          <= 1'b1;
              status        <= STAT_BADADDR;
              block_address <= '0;
              state         <= ST_IDLE;
            end
          end
        end

        ST_MRD: begin
          state <= ST_MCHK;
        end

        ST_MCHK: begin
          done          <= 1'b1;
          status        <= mark_used ? STAT_BADADDR : STAT_OK;
          block_address <= '0;
          state         <= ST_IDLE;
        end

        ST_MUL: begin
          prod  <= PW'(k_sel) * PW'(block_pitch);
          state <= ST_ADD;
        end

        ST_ADD: begin
          done          <= 1'b1;
          status        <= STAT_OK;
          block_address <= root_address + ADDR_W'(prod);
          state         <= ST_IDLE;
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy = (state != ST_IDLE);

  // A result only closes a command that was in flight
  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state != ST_IDLE) || $past(start))
    else $error("result beat without a command in flight");

  // An accepted command holds the block busy or answers at once
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy || done)
    else $error("accepted command neither started work nor answered");

  // Map writes happen only in the clear pass or on a found free block
  a_map_write: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ST_CLEAR) || (state == ST_SCAN) || (state == ST_MCHK))
    else $error("map written outside clear or take");

  // Failed commands and marks carry a zero address
  a_zero_addr: assert property (@(posedge clk) disable iff (rst)
    (done && (status != STAT_OK)) |-> (block_address == '0))
    else $error("failed command returned a nonzero address");

  // Divider answers only while the block waits for it
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside the mark lookup");

endmodule
`default_nettype wire

### rtl/bba_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bba_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### rtl/bba_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bba_div
// Restoring divider, one quotient bit per cycle, for the mark address lookup.
// ----------------------------------------------------------------------------
module bba_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [bba_pkg::DVD_W-1:0]    dividend,
  input  logic [bba_pkg::SIZE_W-1:0]   divisor,
  output logic                         done,
  output logic [bba_pkg::DVD_W-1:0]    quotient,
  output logic [bba_pkg::SIZE_W-1:0]   remainder
);
  import bba_pkg::*;

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0]  quo;
  logic [SIZE_W-1:0] rem;
  logic [SIZE_W-1:0] dsr;
  logic [STEP_W-1:0] cnt;
  logic              run;

  logic [SIZE_W:0] r_sh;
  logic [SIZE_W:0] r_sub;
  logic            ge;

  always_comb begin
    r_sh  = {rem, quo[DVD_W-1]};
    ge    = r_sh >= {1'b0, dsr};
    r_sub = r_sh - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo <= dividend;
        rem <= '0;
        dsr <= divisor;
        cnt <= STEP_W'(DVD_W);
        run <= 1'b1;
      end else if (run) begin
        rem <= ge ? r_sub[SIZE_W-1:0] : r_sh[SIZE_W-1:0];
        quo <= {quo[DVD_W-2:0], ge};
        cnt <= cnt - STEP_W'(1);
        if (cnt == STEP_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule
`default_nettype wire
